@@ rtl/i8mvrs_pkg.sv @@
// ----------------------------------------------------------------------------
// i8mvrs_pkg
// Shared widths, constants and types of the int8 weight matrix-vector block.
// ----------------------------------------------------------------------------
package i8mvrs_pkg;

  localparam int WeightW = 8;
  localparam int ActW    = 16;
  localparam int ScaleW  = 16;
  localparam int ProdW   = WeightW + ActW;
  localparam int AccW    = 40;
  localparam int MulW    = AccW + ScaleW + 1;
  localparam int ResW    = 32;
  localparam int FracShift = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  localparam int QueueDepthDefault = 2;

  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic [ScaleW-1:0]       scale;
    logic                    end_row;
    logic                    end_mat;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic row_done;
  } back_stat_t;

endpackage

@@ rtl/i8mvrs_front.sv @@
// ----------------------------------------------------------------------------
// i8mvrs_front
// Unpacks an input beat, forms the exact weight times activation product and
// tags it with the row and matrix end flags for the queue.
// ----------------------------------------------------------------------------
module i8mvrs_front
  import i8mvrs_pkg::*;
(
  input  logic [InDataW-1:0] tdata_i,
  input  logic               tlast_i,
  input  logic               tuser_i,
  output entry_t             entry_o
);

  logic signed [WeightW-1:0] weight;
  logic signed [ActW-1:0]    act;

  assign weight = $signed(tdata_i[WeightW-1:0]);
  assign act    = $signed(tdata_i[WeightW+ActW-1:WeightW]);

  always_comb begin
    entry_o.prod    = ProdW'(weight * act);
    entry_o.scale   = tdata_i[WeightW+ActW+ScaleW-1:WeightW+ActW];
    entry_o.end_row = tlast_i;
    entry_o.end_mat = tuser_i;
  end

endmodule

@@ rtl/i8mvrs_queue.sv @@
// ----------------------------------------------------------------------------
// i8mvrs_queue
// Short first-in first-out queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module i8mvrs_queue
  import i8mvrs_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/i8mvrs_back.sv @@
// ----------------------------------------------------------------------------
// i8mvrs_back
// Accumulates products with 40-bit saturation, scales the closed row sum,
// rounds it to Q.0, saturates it to 32 bits and holds it for the output.
// ----------------------------------------------------------------------------
module i8mvrs_back
  import i8mvrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  entry_t              entry_i,
  input  logic                empty_i,
  output back_stat_t          stat_o,
  output logic                tvalid_o,
  input  logic                tready_i,
  output logic [OutDataW-1:0] tdata_o,
  output logic                tlast_o,
  output logic                tuser_o
);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [MulW-1:0] RoundHalf = MulW'(1) <<< (FracShift - 1);
  localparam int RndW = MulW - FracShift;

  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW:0]   sum_wide;
  logic signed [AccW-1:0] sum;
  logic                   pop;
  logic                   mul_ready, prd_ready, out_load;

  logic                   mul_vld_q;
  logic signed [AccW-1:0] mul_sum_q;
  logic [ScaleW-1:0]      mul_scale_q;
  logic                   mul_mat_q;

  logic                   prd_vld_q;
  logic signed [MulW-1:0] prd_q, prd_d;
  logic                   prd_mat_q;

  logic signed [MulW-1:0] rnd_full;
  logic [RndW-1:0]        rnd;
  logic [ResW-1:0]        res_d;
  logic                   sat_d;

  logic                   out_vld_q;
  logic [ResW-1:0]        out_res_q;
  logic                   out_sat_q, out_mat_q;

  assign out_load  = !out_vld_q || tready_i;
  assign prd_ready = !prd_vld_q || out_load;
  assign mul_ready = !mul_vld_q || prd_ready;
  assign pop       = !empty_i && (!entry_i.end_row || mul_ready);

  assign stat_o.pop      = pop;
  assign stat_o.row_done = pop && entry_i.end_row;

  always_comb begin
    sum_wide = {acc_q[AccW-1], acc_q} + (AccW+1)'(entry_i.prod);
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum = sum_wide[AccW] ? AccMin : AccMax;
    end else begin
      sum = sum_wide[AccW-1:0];
    end
    acc_d = acc_q;
    if (pop) begin
      acc_d = entry_i.end_row ? '0 : sum;
    end
  end

  assign prd_d = mul_sum_q * $signed({1'b0, mul_scale_q});

  always_comb begin
    rnd_full = prd_q + RoundHalf;
    rnd      = rnd_full[MulW-1:FracShift];
    sat_d    = 1'b0;
    res_d    = rnd[ResW-1:0];
    if (!rnd[RndW-1] && (|rnd[RndW-2:ResW-1])) begin
      res_d = {1'b0, {(ResW-1){1'b1}}};
      sat_d = 1'b1;
    end else if (rnd[RndW-1] && !(&rnd[RndW-2:ResW-1])) begin
      res_d = {1'b1, {(ResW-1){1'b0}}};
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      mul_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (mul_ready) begin
        mul_vld_q <= pop && entry_i.end_row;
      end
      if (prd_ready) begin
        prd_vld_q <= mul_vld_q;
      end
      if (out_load) begin
        out_vld_q <= prd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && pop && entry_i.end_row) begin
      mul_sum_q   <= sum;
      mul_scale_q <= entry_i.scale;
      mul_mat_q   <= entry_i.end_mat;
    end
    if (prd_ready && mul_vld_q) begin
      prd_q     <= prd_d;
      prd_mat_q <= mul_mat_q;
    end
    if (out_load && prd_vld_q) begin
      out_res_q <= res_d;
      out_sat_q <= sat_d;
      out_mat_q <= prd_mat_q;
    end
  end

  assign tvalid_o = out_vld_q;
  assign tdata_o  = out_res_q;
  assign tlast_o  = out_mat_q;
  assign tuser_o  = out_sat_q;

endmodule

@@ rtl/int8_weight_matvec_row_scale.sv @@
// ----------------------------------------------------------------------------
// int8_weight_matvec_row_scale
// Signed int8 weight matrix-vector product with a per-row Q0.16 scale.
// A row-closing beat passes the queue and the sum, product and output
// registers into a result. Throughput: one input beat per cycle while the
// queue has room, set by the single accumulator add; one result per row end.
// Reset clears the accumulator, the queue and all pipeline valid bits.
// ----------------------------------------------------------------------------
module int8_weight_matvec_row_scale
  import i8mvrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // weight_byte [7:0], activation [23:8], row_scale [39:24]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,   // last_in_row
  input  logic                s_axis_tuser,   // last_row
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // row_result [31:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,   // final_result
  output logic                m_axis_tuser    // saturated
);

  entry_t     front_entry;
  entry_t     q_entry;
  logic       q_full, q_empty, q_push;
  back_stat_t back_stat;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  i8mvrs_front u_front (
    .tdata_i (s_axis_tdata),
    .tlast_i (s_axis_tlast),
    .tuser_i (s_axis_tuser),
    .entry_o (front_entry)
  );

  i8mvrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (back_stat.pop),
    .entry_o (q_entry),
    .empty_o (q_empty)
  );

  i8mvrs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (q_entry),
    .empty_i  (q_empty),
    .stat_o   (back_stat),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser)
  );

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000))
    else $error("saturated result is not at a range limit");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !s_axis_tready)
    else $error("input ready while queue is full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !back_stat.pop && !back_stat.row_done)
    else $error("back end pops an empty queue");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the int8 weight matrix-vector block with row scale.
// Rows of weight and activation beats stream into the slave side. A
// behavioral accumulator in the bench predicts each row result. Every result
// beat on the master side is checked field by field against the oldest
// prediction. Stimulus starts with directed rows: extremes, rounding ties,
// a stray last-row flag and single-element rows. Long rows follow that drive
// the output into saturation. Then come random rows with random gaps and
// stalls on both sides, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i8mvrs_pkg::*;

  localparam int RandomBeats = 400;
  localparam int LongHoldAt = 30;
  localparam int LongHoldCycles = 300;
  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;
  localparam longint ResMax = (longint'(1) <<< (ResW - 1)) - 1;
  localparam longint ResMin = -ResMax - 1;
  localparam longint RoundHalf = longint'(1) <<< (FracShift - 1);

  typedef struct {
    logic signed [WeightW-1:0] weight;
    logic signed [ActW-1:0]    act;
    logic [ScaleW-1:0]         scale;
    logic                      row_end;
    logic                      matrix_end;
    int unsigned               gap;
  } elem_t;

  typedef struct {
    logic signed [ResW-1:0] value;
    logic                   clipped;
    logic                   final_row;
  } row_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  elem_t       beats_pending[$];
  row_out_t    rows_due[$];
  elem_t       on_bus;
  longint      dot_sum = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int          beats_in = 0;
  int          rows_taken = 0;
  int          clipped_seen = 0;
  int          errors = 0;
  row_out_t    want;

  int8_weight_matvec_row_scale dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Adds one element to the running dot product and, on a row end, scales,
  // rounds half up and clips the sum into the expected row result.
  task automatic accumulate_element(input elem_t e);
    longint   sum;
    longint   rounded;
    row_out_t r;
    sum = dot_sum + longint'(e.weight) * longint'(e.act);
    if (sum > AccMax) sum = AccMax;
    if (sum < AccMin) sum = AccMin;
    if (!e.row_end) begin
      dot_sum = sum;
      return;
    end
    rounded = (sum * longint'(e.scale) + RoundHalf) >>> FracShift;
    r.clipped = 1'b0;
    if (rounded > ResMax) begin
      rounded = ResMax;
      r.clipped = 1'b1;
    end else if (rounded < ResMin) begin
      rounded = ResMin;
      r.clipped = 1'b1;
    end
    r.value = rounded[ResW-1:0];
    r.final_row = e.matrix_end;
    rows_due.push_back(r);
    dot_sum = 0;
  endtask

  task automatic queue_elem(input logic [WeightW-1:0] w, input logic [ActW-1:0] a,
                            input logic [ScaleW-1:0] s, input logic row_end,
                            input logic matrix_end, input int unsigned gap);
    elem_t e;
    e.weight = w;
    e.act = a;
    e.scale = s;
    e.row_end = row_end;
    e.matrix_end = matrix_end;
    e.gap = gap;
    beats_pending.push_back(e);
  endtask

  function automatic logic [WeightW-1:0] draw_weight();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return '0;
      default: return WeightW'($urandom);
    endcase
  endfunction

  function automatic logic [ActW-1:0] draw_act();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return ActW'($urandom);
    endcase
  endfunction

  function automatic logic [ScaleW-1:0] draw_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return ScaleW'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (beats_pending.size() != 0 || s_axis_tvalid || rows_due.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      s_axis_tuser <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_element(on_bus);
        beats_in++;
        gap_left = on_bus.gap;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (beats_pending.size() > 0) begin
          on_bus = beats_pending.pop_front();
          s_axis_tdata <= {on_bus.scale, on_bus.act, on_bus.weight};
          s_axis_tlast <= on_bus.row_end;
          s_axis_tuser <= on_bus.matrix_end;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rows_taken++;
        if (rows_due.size() == 0) begin
          $error("row_result: no result expected, got %0d", $signed(m_axis_tdata));
          errors++;
        end else begin
          want = rows_due.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("row_result: expected %0d, got %0d", want.value, $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser !== want.clipped) begin
            $error("saturated: expected %0b, got %0b", want.clipped, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== want.final_row) begin
            $error("final_result: expected %0b, got %0b", want.final_row, m_axis_tlast);
            errors++;
          end
        end
        if (m_axis_tuser === 1'b1) clipped_seen++;
        if (rows_taken == LongHoldAt) stall_left = LongHoldCycles;
        else if (rows_taken[6]) stall_left = 0;
        else stall_left = $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int          n;
    int          len;
    logic [ScaleW-1:0] s;
    logic        mat;
    int unsigned g;
    bit          calm;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_elem(8'h7F, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h80, 16'h8000, 16'hFFFF, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h80, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1, $urandom_range(0, 11));
    queue_elem(8'h7F, 16'h8000, 16'h0000, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h7F, 16'h8000, 16'h0001, 1'b1, 1'b1, $urandom_range(0, 11));
    queue_elem(8'h01, 16'h0001, 16'h8000, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'hFF, 16'h0001, 16'h8000, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h01, 16'hFFFF, 16'h0001, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b1, $urandom_range(0, 11));
    queue_elem(8'h55, 16'h1234, 16'hAAAA, 1'b0, 1'b1, $urandom_range(0, 11));
    queue_elem(8'hAA, 16'hEDCB, 16'h5555, 1'b0, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h7F, 16'h7FFF, 16'h1000, 1'b1, 1'b0, $urandom_range(0, 11));
    queue_elem(8'h80, 16'h8000, 16'hFFFF, 1'b0, 1'b1, 0);
    queue_elem(8'h80, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 0);
    queue_elem(8'h01, 16'h0800, 16'h8001, 1'b1, 1'b1, 0);
    wait_drained();

    // 32-bit output clipping at both limits.
    for (int i = 0; i < 600; i++)
      queue_elem(8'h7F, 16'h7FFF, 16'hFFFF, i == 599, 1'b0, 0);
    for (int i = 0; i < 600; i++)
      queue_elem(8'h80, 16'h7FFF, 16'hFFFF, i == 599, 1'b1, 0);
    wait_drained();

    n = 0;
    while (n < RandomBeats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      s = draw_scale();
      mat = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        calm = ((n / 128) % 3 == 0);
        g = calm ? 0 : $urandom_range(0, 11);
        if (k == len - 1)
          queue_elem(draw_weight(), draw_act(), s, 1'b1, mat, g);
        else
          queue_elem(draw_weight(), draw_act(), ScaleW'($urandom), 1'b0,
                     1'($urandom_range(0, 1)), g);
        n++;
      end
    end
    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("Drove %0d input beats and checked %0d row results, %0d of them clipped,",
             beats_in, rows_taken, clipped_seen);
    $display("including long rows that clipped the output at both limits.");
    if (errors == 0) begin
      $display("int8_weight_matvec_row_scale: match");
    end else begin
      $display("int8_weight_matvec_row_scale: mismatch");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("int8_weight_matvec_row_scale: mismatch");
    $finish;
  end

endmodule
